// ===== hdl/vpn_pkg.sv =====
`timescale 1ns / 1ps

package vpn_pkg;

  localparam int OP_BITS = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_DOT       = 3'd0,
    OP_LENGTH    = 3'd1,
    OP_NORMALIZE = 3'd2,
    OP_PROJECT   = 3'd3,
    OP_REJECT    = 3'd4
  } op_t;

endpackage

// ===== hdl/vpn_req_if.sv =====
`timescale 1ns / 1ps

interface vpn_req_if #(parameter int W = 32) ();
  import vpn_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  operation;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;

  modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// ===== hdl/vpn_rsp_if.sv =====
`timescale 1ns / 1ps

interface vpn_rsp_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;
  logic signed [W-1:0] vec_z;
  logic signed [W-1:0] scalar;
  logic                zero_divisor;

  modport source (output valid, vec_x, vec_y, vec_z, scalar, zero_divisor, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, scalar, zero_divisor, output ready);
endinterface

// ===== hdl/vpn_delay.sv =====
`timescale 1ns / 1ps

module vpn_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// ===== hdl/vpn_sqrt_cell.sv =====
`timescale 1ns / 1ps

// one root bit per cell, two radicand bits consumed
module vpn_sqrt_cell #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*W-1:0]   s_in,
  input  logic [W+1:0]     rem_in,
  input  logic [W-1:0]     root_in,
  output logic [2*W-1:0]   s_out,
  output logic [W+1:0]     rem_out,
  output logic [W-1:0]     root_out
);

  logic [W+3:0] cur;
  logic [W+3:0] trial;
  logic         ge;

  assign cur   = {rem_in, s_in[2*W-1:2*W-2]};
  assign trial = (W+4)'({root_in, 2'b01});
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      s_out    <= {s_in[2*W-3:0], 2'b00};
      rem_out  <= ge ? (W+2)'(cur - trial) : cur[W+1:0];
      root_out <= {root_in[W-2:0], ge};
    end
  end

endmodule

// ===== hdl/vpn_div_cell.sv =====
`timescale 1ns / 1ps

// restoring division, one quotient bit per cell; quotient shifts in behind numerator
module vpn_div_cell #(
  parameter int NB = 48,
  parameter int DB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] nq_in,
  input  logic [DB-1:0] rem_in,
  input  logic [DB-1:0] dv_in,
  output logic [NB-1:0] nq_out,
  output logic [DB-1:0] rem_out,
  output logic [DB-1:0] dv_out
);

  logic [DB:0] cur;
  logic        ge;

  assign cur = {rem_in, nq_in[NB-1]};
  assign ge  = cur >= {1'b0, dv_in};

  always_ff @(posedge clk) begin
    if (en) begin
      nq_out  <= {nq_in[NB-2:0], ge};
      rem_out <= ge ? DB'(cur - {1'b0, dv_in}) : cur[DB-1:0];
      dv_out  <= dv_in;
    end
  end

endmodule

// ===== hdl/vec3_project_normalize_unit.sv =====
`timescale 1ns / 1ps

// Vector unit on signed fixed-point triples: dot, length, normalize, project and reject.
// One word is taken every cycle while the output queue is not full. Each result passes
// through the square root cell chain (WORD_BITS cells) followed by the normalize divider
// chain (WORD_BITS+FRAC_BITS cells), which together match the projection divider chain
// (2*WORD_BITS+FRAC_BITS cells) running beside them, one bit per cell, plus three stages in
// front, four behind and the output queue.
// A two-word output queue lets the pipe keep accepting while a result waits; the whole
// pipe holds when the queue is full. Division by a zero magnitude gives a zero vector
// with zero_divisor set. The interface instances must be built with W = WORD_BITS.
module vec3_project_normalize_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  vpn_req_if.sink   req,
  vpn_rsp_if.source rsp
);
  import vpn_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int CH  = 2*W + F;
  localparam int LAT = CH + 7;
  localparam int TB  = (W + F + 3 < 64) ? W + F + 3 : 64;
  localparam int TL  = TB / 2;
  localparam int TH  = TB - TL;
  localparam int NNB = W + F;
  localparam int PNB = 2*W + F;
  localparam int PW  = W + TB;
  localparam int QW  = PW - F;
  localparam int XW  = 2*W + TB + 2;
  localparam int OW  = 4*W + 1;
  localparam int SBW = 7*W + 5;

  localparam logic signed [XW-1:0] SMAX = XW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN = ~SMAX;
  localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [TB-1:0] TMAX = {1'b0, {(TB-1){1'b1}}};
  localparam logic [TB-1:0] TMIN = {1'b1, {(TB-1){1'b0}}};

  function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic [W-1:0] r;
    if (v > SMAX) r = MAXW;
    else if (v < SMIN) r = MINW;
    else r = v[W-1:0];
    return r;
  endfunction

  logic             en;
  logic [1:0]       cnt;
  logic [LAT-1:0]   vld;
  logic             push;
  logic             pop;

  assign en        = ~cnt[1];
  assign req.ready = en & ~rst;
  assign push      = en & vld[LAT-1];
  assign pop       = rsp.valid & rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], req.valid};
    end
  end

  // stage 1: products
  logic signed [W-1:0]   a_in [3];
  logic signed [W-1:0]   b_in [3];
  logic signed [2*W-1:0] pab [3];
  logic signed [2*W-1:0] paa [3];
  logic signed [2*W-1:0] pbb [3];
  logic [OP_BITS-1:0]    op1;
  logic signed [W-1:0]   a1 [3];
  logic signed [W-1:0]   b1 [3];

  assign a_in[0] = req.a_x;
  assign a_in[1] = req.a_y;
  assign a_in[2] = req.a_z;
  assign b_in[0] = req.b_x;
  assign b_in[1] = req.b_y;
  assign b_in[2] = req.b_z;

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= req.operation;
      for (int i = 0; i < 3; i++) begin
        pab[i] <= (2*W)'(a_in[i]) * (2*W)'(b_in[i]);
        paa[i] <= (2*W)'(a_in[i]) * (2*W)'(a_in[i]);
        pbb[i] <= (2*W)'(b_in[i]) * (2*W)'(b_in[i]);
        a1[i]  <= a_in[i];
        b1[i]  <= b_in[i];
      end
    end
  end

  // stage 2: sums
  logic signed [2*W+1:0] ab2;
  logic [2*W-1:0]        aa2;
  logic [2*W-1:0]        bb2;
  logic [OP_BITS-1:0]    op2;
  logic signed [W-1:0]   a2 [3];
  logic signed [W-1:0]   b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      ab2 <= (2*W+2)'(pab[0]) + (2*W+2)'(pab[1]) + (2*W+2)'(pab[2]);
      aa2 <= $unsigned(paa[0]) + $unsigned(paa[1]) + $unsigned(paa[2]);
      bb2 <= $unsigned(pbb[0]) + $unsigned(pbb[1]) + $unsigned(pbb[2]);
      op2 <= op1;
      a2  <= a1;
      b2  <= b1;
    end
  end

  // stage 3: magnitudes, dot result
  logic signed [2*W+1:0] ab_abs;
  logic                  ab_neg3;
  logic [2*W-1:0]        abmag3;
  logic [2*W-1:0]        aa3;
  logic [2*W-1:0]        bb3;
  logic                  bbz3;
  logic [W-1:0]          dot3;
  logic [OP_BITS-1:0]    op3;
  logic signed [W-1:0]   a3 [3];
  logic signed [W-1:0]   b3 [3];
  logic [W-1:0]          amag3 [3];

  assign ab_abs = ab2[2*W+1] ? -ab2 : ab2;

  always_ff @(posedge clk) begin
    if (en) begin
      ab_neg3 <= ab2[2*W+1];
      abmag3  <= ab_abs[2*W-1:0];
      aa3     <= aa2;
      bb3     <= bb2;
      bbz3    <= bb2 == '0;
      dot3    <= sat_w(XW'(ab2 >>> F));
      op3     <= op2;
      a3      <= a2;
      b3      <= b2;
      for (int i = 0; i < 3; i++) begin
        amag3[i] <= a2[i][W-1] ? $unsigned(-a2[i]) : $unsigned(a2[i]);
      end
    end
  end

  // square root chain
  logic [2*W-1:0] sq_s [W+1];
  logic [W+1:0]   sq_r [W+1];
  logic [W-1:0]   sq_q [W+1];

  assign sq_s[0] = aa3;
  assign sq_r[0] = '0;
  assign sq_q[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_sq
    vpn_sqrt_cell #(.W(W)) u_cell (
      .clk      (clk),
      .en       (en),
      .s_in     (sq_s[k]),
      .rem_in   (sq_r[k]),
      .root_in  (sq_q[k]),
      .s_out    (sq_s[k+1]),
      .rem_out  (sq_r[k+1]),
      .root_out (sq_q[k+1])
    );
  end

  logic [3*W-1:0] amag_d;

  vpn_delay #(.WIDTH(3*W), .DEPTH(W)) u_amag_dly (
    .clk (clk),
    .en  (en),
    .d   ({amag3[2], amag3[1], amag3[0]}),
    .q   (amag_d)
  );

  // normalize divider chains
  logic [NNB-1:0] nd_nq  [3][NNB+1];
  logic [W-1:0]   nd_rem [3][NNB+1];
  logic [W-1:0]   nd_dv  [3][NNB+1];

  for (genvar j = 0; j < 3; j++) begin : g_nd
    assign nd_nq[j][0]  = {amag_d[j*W +: W], {F{1'b0}}};
    assign nd_rem[j][0] = '0;
    assign nd_dv[j][0]  = sq_q[W];
    for (genvar k = 0; k < NNB; k++) begin : g_cell
      vpn_div_cell #(.NB(NNB), .DB(W)) u_cell (
        .clk     (clk),
        .en      (en),
        .nq_in   (nd_nq[j][k]),
        .rem_in  (nd_rem[j][k]),
        .dv_in   (nd_dv[j][k]),
        .nq_out  (nd_nq[j][k+1]),
        .rem_out (nd_rem[j][k+1]),
        .dv_out  (nd_dv[j][k+1])
      );
    end
  end

  // projection ratio divider chain
  logic [PNB-1:0] pd_nq  [PNB+1];
  logic [2*W-1:0] pd_rem [PNB+1];
  logic [2*W-1:0] pd_dv  [PNB+1];

  assign pd_nq[0]  = {abmag3, {F{1'b0}}};
  assign pd_rem[0] = '0;
  assign pd_dv[0]  = bb3;

  for (genvar k = 0; k < PNB; k++) begin : g_pd
    vpn_div_cell #(.NB(PNB), .DB(2*W)) u_cell (
      .clk     (clk),
      .en      (en),
      .nq_in   (pd_nq[k]),
      .rem_in  (pd_rem[k]),
      .dv_in   (pd_dv[k]),
      .nq_out  (pd_nq[k+1]),
      .rem_out (pd_rem[k+1]),
      .dv_out  (pd_dv[k+1])
    );
  end

  logic [SBW-1:0] sb_q;

  vpn_delay #(.WIDTH(SBW), .DEPTH(CH)) u_sb_dly (
    .clk (clk),
    .en  (en),
    .d   ({op3, dot3, a3[2], a3[1], a3[0], b3[2], b3[1], b3[0], ab_neg3, bbz3}),
    .q   (sb_q)
  );

  logic [OP_BITS-1:0]  op_e;
  logic [W-1:0]        dot_e;
  logic signed [W-1:0] a_e [3];
  logic signed [W-1:0] b_e [3];
  logic                abneg_e;
  logic                bbz_e;
  logic [W-1:0]        len_e;
  logic [PNB-1:0]      qp_e;

  assign op_e    = sb_q[2+7*W +: OP_BITS];
  assign dot_e   = sb_q[2+6*W +: W];
  assign abneg_e = sb_q[1];
  assign bbz_e   = sb_q[0];
  assign len_e   = nd_dv[0][NNB];
  assign qp_e    = pd_nq[PNB];

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign a_e[i] = sb_q[2+3*W+i*W +: W];
    assign b_e[i] = sb_q[2+i*W +: W];
  end

  // E1: signs and clamps
  logic [W-1:0]         nrm_next [3];
  logic [TB-1:0]        t_next;
  logic                 big_t;
  logic [OP_BITS-1:0]   op4;
  logic signed [W-1:0]  a4 [3];
  logic signed [W-1:0]  b4 [3];
  logic                 bbz4;
  logic                 lz4;
  logic [W-1:0]         dot4;
  logic [W-1:0]         len4;
  logic [W-1:0]         nrm4 [3];
  logic signed [TB-1:0] t4;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (nd_nq[j][NNB][NNB-1:W-1] != '0) begin
        nrm_next[j] = a_e[j][W-1] ? MINW : MAXW;
      end else begin
        nrm_next[j] = a_e[j][W-1] ? -nd_nq[j][NNB][W-1:0] : nd_nq[j][NNB][W-1:0];
      end
    end
    big_t = qp_e[PNB-1:TB-1] != '0;
    if (big_t) begin
      t_next = abneg_e ? TMIN : TMAX;
    end else begin
      t_next = abneg_e ? -qp_e[TB-1:0] : qp_e[TB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op4  <= op_e;
      a4   <= a_e;
      b4   <= b_e;
      bbz4 <= bbz_e;
      lz4  <= len_e == '0;
      dot4 <= dot_e;
      len4 <= len_e[W-1] ? MAXW : len_e;
      nrm4 <= nrm_next;
      t4   <= t_next;
    end
  end

  // E2: partial products b * t
  logic signed [W+TL:0]   pl5 [3];
  logic signed [W+TH-1:0] ph5 [3];
  logic [OP_BITS-1:0]     op5;
  logic signed [W-1:0]    a5 [3];
  logic                   bbz5;
  logic                   lz5;
  logic [W-1:0]           dot5;
  logic [W-1:0]           len5;
  logic [W-1:0]           nrm5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl5[i] <= (W+TL+1)'(b4[i]) * $signed((W+TL+1)'({1'b0, t4[TL-1:0]}));
        ph5[i] <= (W+TH)'(b4[i]) * (W+TH)'($signed(t4[TB-1:TL]));
      end
      op5  <= op4;
      a5   <= a4;
      bbz5 <= bbz4;
      lz5  <= lz4;
      dot5 <= dot4;
      len5 <= len4;
      nrm5 <= nrm4;
    end
  end

  // E3: projection sum and scale
  logic signed [PW-1:0] pfull [3];
  logic signed [QW-1:0] pq6 [3];
  logic [OP_BITS-1:0]   op6;
  logic signed [W-1:0]  a6 [3];
  logic                 bbz6;
  logic                 lz6;
  logic [W-1:0]         dot6;
  logic [W-1:0]         len6;
  logic [W-1:0]         nrm6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pfull[i] = (PW'(ph5[i]) <<< TL) + PW'(pl5[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pq6[i] <= pfull[i][PW-1:F];
      end
      op6  <= op5;
      a6   <= a5;
      bbz6 <= bbz5;
      lz6  <= lz5;
      dot6 <= dot5;
      len6 <= len5;
      nrm6 <= nrm5;
    end
  end

  // E4: result select
  logic [W-1:0] vec_sel [3];
  logic [W-1:0] scl_sel;
  logic         zd_sel;
  logic [OW-1:0] res;

  always_comb begin
    scl_sel = '0;
    zd_sel  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vec_sel[i] = '0;
    end
    unique case (op6)
      OP_DOT: begin
        scl_sel = dot6;
      end
      OP_LENGTH: begin
        scl_sel = len6;
      end
      OP_NORMALIZE: begin
        zd_sel = lz6;
        if (!lz6) vec_sel = nrm6;
      end
      OP_PROJECT: begin
        zd_sel = bbz6;
        for (int i = 0; i < 3; i++) begin
          if (!bbz6) vec_sel[i] = sat_w(XW'(pq6[i]));
        end
      end
      OP_REJECT: begin
        zd_sel = bbz6;
        for (int i = 0; i < 3; i++) begin
          if (!bbz6) vec_sel[i] = sat_w(XW'(a6[i]) - XW'(pq6[i]));
        end
      end
      default: begin
        scl_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= {zd_sel, scl_sel, vec_sel[2], vec_sel[1], vec_sel[0]};
    end
  end

  // output queue, two words
  logic [OW-1:0] q0;
  logic [OW-1:0] q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) q0 <= res;
      else q1 <= res;
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (push && pop) begin
      if (cnt == 2'd1) begin
        q0 <= res;
      end else begin
        q0 <= q1;
        q1 <= res;
      end
    end
  end

  assign rsp.valid        = cnt != 2'd0;
  assign rsp.vec_x        = q0[W-1:0];
  assign rsp.vec_y        = q0[2*W-1:W];
  assign rsp.vec_z        = q0[3*W-1:2*W];
  assign rsp.scalar       = q0[4*W-1:3*W];
  assign rsp.zero_divisor = q0[4*W];

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst) push |=> rsp.valid)
    else $error("pushed word not visible at output");

  a_zd_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_divisor |->
      rsp.vec_x == '0 && rsp.vec_y == '0 && rsp.vec_z == '0 && rsp.scalar == '0)
    else $error("zero divisor with nonzero result");

  a_scalar_only: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.scalar != '0 |->
      rsp.vec_x == '0 && rsp.vec_y == '0 && rsp.vec_z == '0 && !rsp.zero_divisor)
    else $error("scalar result with vector bits set");
`endif

endmodule
